/* src/touch_average_hysteresis_debounce_defines.svh */
// Assertion macros for the touch averaging block.
// Included by the top level; no other dependencies.
`ifndef TOUCH_AVERAGE_HYSTERESIS_DEBOUNCE_DEFINES_SVH
`define TOUCH_AVERAGE_HYSTERESIS_DEBOUNCE_DEFINES_SVH

`ifndef SYNTH
`define TAHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TAHD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TAHD_ASSERT(lbl, prop, msg)
`define TAHD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/tahd_pkg.sv */
// Shared types and register codes for the touch averaging block.
// No dependencies.
package tahd_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned FrameW = 32;
  localparam int unsigned LimitW = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HYST_LOW   = 3'd0,
    CFG_HYST_HIGH  = 3'd1,
    CFG_LOW_WORD   = 3'd2,
    CFG_HIGH_WORD  = 3'd3,
    CFG_DIGITAL    = 3'd4,
    CFG_INVERT     = 3'd5,
    CFG_DEB_LIMIT  = 3'd6
  } tahd_cfg_idx_e;

  typedef struct packed {
    logic [WordW-1:0]  hyst_low;
    logic [WordW-1:0]  hyst_high;
    logic [WordW-1:0]  low_word;
    logic [WordW-1:0]  high_word;
    logic              digital;
    logic              invert;
    logic [LimitW-1:0] deb_limit;
  } tahd_cfg_t;

  typedef struct packed {
    logic              level;
    logic [LimitW-1:0] agree;
    logic              flip;
    logic [WordW-1:0]  word;
  } tahd_dbn_t;

endpackage

/* src/tahd_debounce.sv */
// Hysteresis test, debounce count and level-to-word mapping for one mean.
// Depends on tahd_pkg.
module tahd_debounce (
  input  tahd_pkg::tahd_cfg_t            cfg_i,
  input  logic [tahd_pkg::WordW-1:0]     mean_i,
  input  logic                           level_i,
  input  logic [tahd_pkg::LimitW-1:0]    agree_i,
  output tahd_pkg::tahd_dbn_t            dbn_o
);
  import tahd_pkg::*;

  logic              qualifies;
  logic [LimitW-1:0] agree_inc;
  logic              flip;
  logic              level_nxt;

  assign qualifies = level_i ? (mean_i >= cfg_i.hyst_high) : (mean_i <= cfg_i.hyst_low);
  assign agree_inc = agree_i + LimitW'(1);
  assign flip      = qualifies && (agree_inc > cfg_i.deb_limit);
  assign level_nxt = level_i ^ flip;

  always_comb begin
    dbn_o.level = level_nxt;
    dbn_o.flip  = flip;
    dbn_o.agree = (qualifies && !flip) ? agree_inc : '0;
    dbn_o.word  = (level_nxt ^ cfg_i.invert) ? cfg_i.low_word : cfg_i.high_word;
  end

endmodule

/* src/touch_average_hysteresis_debounce.sv */
// Touch sample averaging with hysteresis debounce and status reads.
// Depends on tahd_pkg, tahd_debounce and the assertion macro header.
//
// One item per clock cycle while m_axis_tready_i stays high, through an input
// register, then the state update and result register. Each item
// passes one fixed-reciprocal multiplier (mean of SAMPLES_AVERAGED samples)
// and the debounce compares in that single stage. The input side is ready
// whenever the result register is empty or being taken in the same cycle,
// so s_axis_tready_o follows m_axis_tready_i combinationally. Configuration
// writes are taken every cycle and should only be made while idle.
`include "touch_average_hysteresis_debounce_defines.svh"

module touch_average_hysteresis_debounce #(
  parameter int unsigned SAMPLES_AVERAGED = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: sample[15:0], frame_count[47:16], clear_transitions[48], zero pad
  input  logic [55:0]                       s_axis_tdata_i,
  // tuser: func[0]
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: public_value[15:0], value_updated[16], reported_level[17],
  //        transition_count[33:18], frames_since_change[49:34], zero pad
  output logic [55:0]                       m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tahd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tahd_pkg::WordW-1:0]        cfg_data_i
);
  import tahd_pkg::*;

  localparam int unsigned LogN  = $clog2(SAMPLES_AVERAGED);
  localparam int unsigned SumW  = WordW + LogN;
  localparam int unsigned TallyW = (SAMPLES_AVERAGED > 1) ? LogN : 1;
  localparam int unsigned Shift = SumW + LogN;
  localparam int unsigned RecipW = SumW + 1;
  localparam longint unsigned RecipL =
      ((64'd1 << Shift) + 64'(SAMPLES_AVERAGED) - 64'd1) / 64'(SAMPLES_AVERAGED);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
  localparam logic [TallyW-1:0] TallyLast = TallyW'(SAMPLES_AVERAGED - 1);

  // configuration
  tahd_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HYST_LOW:  cfg_q.hyst_low  <= cfg_data_i;
        CFG_HYST_HIGH: cfg_q.hyst_high <= cfg_data_i;
        CFG_LOW_WORD:  cfg_q.low_word  <= cfg_data_i;
        CFG_HIGH_WORD: cfg_q.high_word <= cfg_data_i;
        CFG_DIGITAL:   cfg_q.digital   <= cfg_data_i[0];
        CFG_INVERT:    cfg_q.invert    <= cfg_data_i[0];
        CFG_DEB_LIMIT: cfg_q.deb_limit <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_valid_q;
  logic              in_func_q;
  logic [WordW-1:0]  in_sample_q;
  logic [FrameW-1:0] in_frame_q;
  logic              in_clear_q;
  logic              out_valid_q;
  logic              advance;
  logic              fire;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_func_q   <= s_axis_tuser_i;
      in_sample_q <= s_axis_tdata_i[15:0];
      in_frame_q  <= s_axis_tdata_i[47:16];
      in_clear_q  <= s_axis_tdata_i[48];
    end
  end

  // state
  logic [SumW-1:0]   sum_q,  sum_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic [WordW-1:0]  held_q, held_d;
  logic              level_q, level_d;
  logic [LimitW-1:0] agree_q, agree_d;
  logic [WordW-1:0]  change_cnt_q, change_cnt_d;
  logic [FrameW-1:0] last_frame_q, last_frame_d;

  logic [SumW-1:0]        sum_acc;
  logic                   done;
  logic [SumW+RecipW-1:0] prod;
  logic [WordW-1:0]       mean;
  tahd_dbn_t              dbn;
  logic                   run_dbn;
  logic [WordW-1:0]       reported_cnt;
  logic [FrameW-1:0]      since_full;
  logic [WordW-1:0]       since;

  assign sum_acc = sum_q + SumW'(in_sample_q);
  assign done    = !in_func_q && (tally_q == TallyLast);
  assign prod    = {{RecipW{1'b0}}, sum_acc} * {{SumW{1'b0}}, Recip};
  assign mean    = prod[Shift +: WordW];
  assign run_dbn = done && cfg_q.digital;

  tahd_debounce u_debounce (
    .cfg_i   (cfg_q),
    .mean_i  (mean),
    .level_i (level_q),
    .agree_i (agree_q),
    .dbn_o   (dbn)
  );

  always_comb begin
    sum_d        = sum_q;
    tally_d      = tally_q;
    held_d       = held_q;
    level_d      = level_q;
    agree_d      = agree_q;
    change_cnt_d = change_cnt_q;
    last_frame_d = last_frame_q;
    if (!in_func_q) begin
      sum_d   = done ? '0 : sum_acc;
      tally_d = done ? '0 : tally_q + TallyW'(1);
    end
    if (done) begin
      held_d = mean;
    end
    if (run_dbn) begin
      held_d  = dbn.word;
      level_d = dbn.level;
      agree_d = dbn.agree;
      if (dbn.flip) begin
        change_cnt_d = change_cnt_q + WordW'(1);
        last_frame_d = in_frame_q;
      end
    end
    reported_cnt = change_cnt_d;
    if (in_func_q && in_clear_q) begin
      change_cnt_d = '0;
    end
    since_full = in_frame_q - last_frame_d;
    since      = (since_full > FrameW'(16'hFFFF)) ? 16'hFFFF : since_full[WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      tally_q      <= '0;
      held_q       <= '0;
      level_q      <= 1'b0;
      agree_q      <= '0;
      change_cnt_q <= '0;
      last_frame_q <= '0;
    end else if (fire) begin
      sum_q        <= sum_d;
      tally_q      <= tally_d;
      held_q       <= held_d;
      level_q      <= level_d;
      agree_q      <= agree_d;
      change_cnt_q <= change_cnt_d;
      last_frame_q <= last_frame_d;
    end
  end

  // result register
  logic [55:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {6'd0, since, reported_cnt, level_d, done, held_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `TAHD_ASSERT(a_tally_range, (tally_q <= TallyLast), "sample tally beyond average length")
  `TAHD_ASSERT(a_level_counts,
    ((level_q != $past(level_q)) |-> (change_cnt_q == $past(change_cnt_q) + WordW'(1))),
    "level changed without counting a transition")
  `TAHD_ASSERT_ALWAYS(a_ready_when_empty, (!out_valid_q |-> s_axis_tready_o),
    "input stalled with empty result register")

endmodule

/* verif/touch_average_hysteresis_debounce_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the touch averaging block: tracks config writes, predicts each status item.
// Compares every accepted result with the oldest prediction. Depends on tahd_pkg.
module touch_average_hysteresis_debounce_checker
  import tahd_pkg::*;
#(
  parameter int unsigned SAMPLES_AVERAGED = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tdata: sample[15:0], frame_count[47:16], clear_transitions[48]
  input  logic [55:0]        s_tdata_i,
  // tuser: func[0]
  input  logic               s_tuser_i,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  // tdata: public_value[15:0], value_updated[16], reported_level[17],
  //        transition_count[33:18], frames_since_change[49:34]
  input  logic [55:0]        m_tdata_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 averages_o,
  output int                 reads_o,
  output int                 flips_o
);

  typedef struct packed {
    logic [15:0] since;
    logic [15:0] transitions;
    logic        level;
    logic        updated;
    logic [15:0] public_value;
  } touch_status_t;

  touch_status_t status_q[$];

  tahd_cfg_t   cfg;
  logic [18:0] acc_sum;
  int          acc_tally;
  logic [15:0] held_word;
  logic        level;
  logic [7:0]  agree;
  logic [15:0] changes;
  logic [31:0] last_frame;
  int          mismatches;
  int          checked;
  int          averages;
  int          reads;
  int          flips;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic predict_status(input logic is_read, input logic [15:0] smp,
                                input logic [31:0] frm, input logic clr,
                                output touch_status_t st);
    logic [31:0] delta;
    logic        qualifies;
    st = '0;
    if (!is_read) begin
      acc_sum = acc_sum + 19'(smp);
      acc_tally++;
      if (acc_tally >= SAMPLES_AVERAGED) begin
        held_word = 16'(acc_sum / SAMPLES_AVERAGED);
        acc_sum   = '0;
        acc_tally = 0;
        st.updated = 1'b1;
        averages++;
        if (cfg.digital) begin
          qualifies = level ? (held_word >= cfg.hyst_high) : (held_word <= cfg.hyst_low);
          if (qualifies) begin
            agree = agree + 8'd1;
            if (agree > cfg.deb_limit) begin
              level      = ~level;
              agree      = '0;
              changes    = changes + 16'd1;
              last_frame = frm;
              flips++;
            end
          end else begin
            agree = '0;
          end
          held_word = (level ^ cfg.invert) ? cfg.low_word : cfg.high_word;
        end
      end
    end else begin
      reads++;
    end
    delta = frm - last_frame;
    st.public_value = held_word;
    st.level        = level;
    st.transitions  = changes;
    st.since        = (delta > 32'd65535) ? 16'hFFFF : delta[15:0];
    if (is_read && clr) changes = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    touch_status_t want;
    touch_status_t got;
    if (!rst_ni) begin
      status_q.delete();
      cfg        = '0;
      acc_sum    = '0;
      acc_tally  = 0;
      held_word  = '0;
      level      = 1'b0;
      agree      = '0;
      changes    = '0;
      last_frame = '0;
      mismatches = 0;
      checked    = 0;
      averages   = 0;
      reads      = 0;
      flips      = 0;
      errors_o   <= 0;
      pending_o  <= 0;
      checked_o  <= 0;
      averages_o <= 0;
      reads_o    <= 0;
      flips_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (tahd_cfg_idx_e'(cfg_index_i))
          CFG_HYST_LOW:  cfg.hyst_low  = cfg_data_i;
          CFG_HYST_HIGH: cfg.hyst_high = cfg_data_i;
          CFG_LOW_WORD:  cfg.low_word  = cfg_data_i;
          CFG_HIGH_WORD: cfg.high_word = cfg_data_i;
          CFG_DIGITAL:   cfg.digital   = cfg_data_i[0];
          CFG_INVERT:    cfg.invert    = cfg_data_i[0];
          CFG_DEB_LIMIT: cfg.deb_limit = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[49:0];
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("public_value", 32'(want.public_value), 32'(got.public_value));
          check_field("value_updated", 32'(want.updated), 32'(got.updated));
          check_field("reported_level", 32'(want.level), 32'(got.level));
          check_field("transition_count", 32'(want.transitions), 32'(got.transitions));
          check_field("frames_since_change", 32'(want.since), 32'(got.since));
          checked++;
        end
        if (m_tdata_i[55:50] !== '0) begin
          $display("%0t: pad bits expected 0x0, got 0x%0h", $time, m_tdata_i[55:50]);
          mismatches++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_status(s_tuser_i, s_tdata_i[15:0], s_tdata_i[47:16], s_tdata_i[48], want);
        status_q.push_back(want);
      end
      errors_o   <= mismatches;
      pending_o  <= status_q.size();
      checked_o  <= checked;
      averages_o <= averages;
      reads_o    <= reads;
      flips_o    <= flips;
    end
  end

endmodule

/* verif/touch_average_hysteresis_debounce_tb.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for the touch averaging block: directed items, then random phases.
// Depends on tahd_pkg, the block and touch_average_hysteresis_debounce_checker.
module touch_average_hysteresis_debounce_tb;
  import tahd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum logic [1:0] {SPAN_LOW, SPAN_HIGH, SPAN_ANY, SPAN_EDGE} sample_span_e;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic [55:0]        s_axis_tdata_i  = '0;
  logic               s_axis_tuser_i  = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [55:0]        m_axis_tdata_o;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic [WordW-1:0]   cfg_data_i      = '0;

  int errors, pending, checked, averages, reads, flips;

  int          cycle_count = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int          rx_left = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  int          phases_run = 0;
  int          group_pos = 0;
  logic [31:0] frame_now = '0;
  tahd_cfg_t   settings;

  touch_average_hysteresis_debounce u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .m_axis_tdata_o,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  touch_average_hysteresis_debounce_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_i  (s_axis_tready_o),
    .m_tdata_i   (m_axis_tdata_o),
    .m_tvalid_i  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .cfg_valid_i,
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .averages_o  (averages),
    .reads_o     (reads),
    .flips_o     (flips)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("touch_average_hysteresis_debounce_tb: FAIL");
      $finish;
    end
  end

  // result-side back-pressure, switching to a random pattern when rx_left runs out
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:  m_axis_tready_i <= 1'b1;
      RX_MOSTLY:  m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      RX_SPARSE:  m_axis_tready_i <= ($urandom_range(0, 9) < 3);
      default:    m_axis_tready_i <= (cycle_count[2:0] == 3'd0);
    endcase
  end

  task automatic send_item(logic is_read, logic [15:0] smp, logic [31:0] frm, logic clr);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= is_read;
    s_axis_tdata_i  <= {7'b0, clr, frm, smp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (!is_read) group_pos = (group_pos + 1) % 8;
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(tahd_cfg_t s);
    tahd_cfg_idx_e idx;
    for (int i = 0; i < 7; i++) begin
      idx = tahd_cfg_idx_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      case (idx)
        CFG_HYST_LOW:  cfg_data_i <= s.hyst_low;
        CFG_HYST_HIGH: cfg_data_i <= s.hyst_high;
        CFG_LOW_WORD:  cfg_data_i <= s.low_word;
        CFG_HIGH_WORD: cfg_data_i <= s.high_word;
        CFG_DIGITAL:   cfg_data_i <= {15'($urandom), s.digital};
        CFG_INVERT:    cfg_data_i <= {15'($urandom), s.invert};
        default:       cfg_data_i <= {8'($urandom), s.deb_limit};
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    phases_run++;
  endtask

  function automatic logic [31:0] next_frame();
    case ($urandom_range(0, 49))
      0:       frame_now = $urandom;
      1:       frame_now = frame_now - $urandom_range(1, 70000);
      2:       frame_now = frame_now + $urandom_range(60000, 140000);
      default: frame_now = frame_now + $urandom_range(0, 3);
    endcase
    return frame_now;
  endfunction

  // only_low keeps every sample at or below the low limit
  task automatic run_samples(int n_samples, bit only_low);
    sample_span_e span;
    int           span_groups;
    logic [15:0]  edge_word;
    logic [15:0]  smp;
    span        = SPAN_ANY;
    span_groups = 0;
    edge_word   = '0;
    for (int i = 0; i < n_samples; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(1'b1, 16'($urandom), next_frame(), 1'($urandom));
      if (group_pos == 0) begin
        if (span_groups == 0) begin
          span        = only_low ? SPAN_LOW : sample_span_e'($urandom_range(0, 3));
          span_groups = $urandom_range(1, 6);
          edge_word   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        span_groups--;
      end
      case (span)
        SPAN_LOW:  smp = 16'($urandom_range(0, settings.hyst_low));
        SPAN_HIGH: smp = 16'($urandom_range(settings.hyst_high, 16'hFFFF));
        SPAN_EDGE: smp = edge_word;
        default:   smp = 16'($urandom);
      endcase
      send_item(1'b0, smp, next_frame(), 1'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // analog mode: full-scale mean, truncated mean, read inside a group, saturation
    settings = '0;
    load_settings(settings);
    send_item(1'b1, 16'h0000, 32'd0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_item(1'b0, 16'hFFFF, 32'(i + 1), 1'b0);
      if (i == 2) send_item(1'b1, 16'h1234, 32'd4, 1'b0);
    end
    for (int i = 0; i < 8; i++)
      send_item(1'b0, i[0] ? 16'hFFFF : 16'h0000, 32'(20 + i), 1'b0);
    send_item(1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b1);

    // digital: one flip, then a read with the frame counter behind it
    wait_idle();
    settings = '{hyst_low: 16'h4000, hyst_high: 16'hC000, low_word: 16'hFFFF,
                 high_word: 16'h0000, digital: 1'b1, invert: 1'b0, deb_limit: 8'd0};
    load_settings(settings);
    for (int i = 0; i < 8; i++)
      send_item(1'b0, 16'(16'h0100 * i), 32'd1000, 1'b0);
    send_item(1'b1, 16'hFFFF, 32'd999, 1'b1);
    send_item(1'b1, 16'h0000, 32'd1005, 1'b0);
    frame_now = 32'd2000;

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: settings = '{hyst_low: 16'hFFFF, hyst_high: 16'h0000, low_word: 16'hFFFF,
                        high_word: 16'h0000, digital: 1'b1, invert: 1'b1, deb_limit: 8'd0};
        1: settings = '{hyst_low: 16'h0000, hyst_high: 16'hFFFF, low_word: 16'h0000,
                        high_word: 16'hFFFF, digital: 1'b1, invert: 1'b0, deb_limit: 8'd1};
        default: begin
          settings.hyst_low  = 16'($urandom_range(0, 16'h7FFF));
          settings.hyst_high = 16'($urandom_range(settings.hyst_low, 16'hFFFF));
          settings.low_word  = 16'($urandom);
          settings.high_word = 16'($urandom);
          settings.digital   = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
          settings.invert    = 1'($urandom);
          settings.deb_limit = 8'($urandom_range(0, 5));
        end
      endcase
      load_settings(settings);
      run_samples(70, 1'b0);
    end

    // limit of 255 with every mean qualifying: level holds
    wait_idle();
    settings = '{hyst_low: 16'($urandom_range(16'h4000, 16'hFFFF)), hyst_high: 16'h0000,
                 low_word: 16'($urandom), high_word: 16'($urandom), digital: 1'b1,
                 invert: 1'($urandom), deb_limit: 8'd255};
    load_settings(settings);
    run_samples(520, 1'b1);

    wait_idle();
    $display("Sent %0d items over %0d setting phases: %0d averages, %0d status reads.",
             items_sent, phases_run, averages, reads);
    $display("Checked %0d results; debounced level changed %0d times.", checked, flips);
    if (errors == 0) begin
      $display("touch_average_hysteresis_debounce_tb: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("touch_average_hysteresis_debounce_tb: FAIL");
    end
    $finish;
  end

endmodule
